// ===== design/lyapunov_exponent_pixel_macros.svh =====
// Assertion macros used by the checker file of the pixel block.
`ifndef LYAPUNOV_EXPONENT_PIXEL_MACROS_SVH
`define LYAPUNOV_EXPONENT_PIXEL_MACROS_SVH

// implication in the same cycle, clocked on clock, quiet during reset
`define LEP_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lep check failed");

// implication into the next cycle, clocked on clock, quiet during reset
`define LEP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lep check failed");

`endif

// ===== design/lep_pkg.sv =====
// Shared constants, command codes and interface types of the pixel block.
package lep_pkg;

   localparam int SEQ_MAX     = 32;
   localparam int RATE_W      = 32;
   localparam int PAT_W       = 32;
   localparam int LEN_W       = 6;
   localparam int STEPS_W     = 16;
   localparam int COUNT_W     = STEPS_W + 1;
   localparam int POS_W       = $clog2(SEQ_MAX);
   localparam int ACC_W       = 38;
   localparam int LN_W        = 24;
   localparam int WORD_W      = 34;
   localparam int SHIFT_W     = 6;
   localparam int FRAC_LOG    = 20;
   localparam int EXP_W       = 7;
   localparam int LG_W        = EXP_W + FRAC_LOG;
   localparam int MAG_W       = 26;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 32;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int NORM_STAGES = 6;
   localparam int SQ_ITERS    = FRAC_LOG;
   localparam int ITER_W      = $clog2(SQ_ITERS);

   localparam logic [MUL_B_W-1:0] LN2_Q32     = 32'd2977044472;
   localparam logic [RATE_W-1:0]  ORBIT_INIT  = 32'h8000_0000;
   localparam logic signed [LN_W-1:0] LOG_FLOOR = -24'sd2097152;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 38'sh1F_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 38'sh20_0000_0000;

   localparam logic [PAT_W-1:0]   PATTERN_RST = 32'd1;
   localparam logic [LEN_W-1:0]   LENGTH_RST  = 6'd2;
   localparam logic [STEPS_W-1:0] WARM_RST    = 16'd600;
   localparam logic [STEPS_W-1:0] MAIN_RST    = 16'd2000;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WARM    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN    = 2'd3;

   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_LOG_LOAD = 4'd2;
   localparam logic [3:0] OP_NORM     = 4'd3;
   localparam logic [3:0] OP_MANT     = 4'd4;
   localparam logic [3:0] OP_SQUARE   = 4'd5;
   localparam logic [3:0] OP_LOG_EXP  = 4'd6;
   localparam logic [3:0] OP_LOG_MUL  = 4'd7;
   localparam logic [3:0] OP_LOG_FIN  = 4'd8;
   localparam logic [3:0] OP_MUL_P    = 4'd9;
   localparam logic [3:0] OP_MUL_X    = 4'd10;
   localparam logic [3:0] OP_STEP_END = 4'd11;
   localparam logic [3:0] OP_PUBLISH  = 4'd12;

   localparam logic [1:0] SRC_A = 2'd0;
   localparam logic [1:0] SRC_B = 2'd1;
   localparam logic [1:0] SRC_D = 2'd2;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] src;
      logic [2:0] stage;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic in_main;
   } status_type;

endpackage

// ===== design/lep_datapath.sv =====
// Datapath: settings, orbit, shared multiplier, log unit and accumulator.
module lep_datapath import lep_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [RATE_W-1:0]      req_a_value,
   input  logic [RATE_W-1:0]      req_b_value,
   input  cmd_type                cmd,
   output status_type             status,
   output logic signed [ACC_W-1:0] rsp_exponent_sum
);

   logic [PAT_W-1:0]   pattern_ff, pattern_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [STEPS_W-1:0] warm_ff, warm_in;
   logic [STEPS_W-1:0] main_ff, main_in;

   logic [RATE_W-1:0]  a_ff, a_in, b_ff, b_in, x_ff, x_in, p_ff, p_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, out_ff, out_in;
   logic [COUNT_W-1:0] step_ff, step_in, total_ff, total_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [WORD_W-1:0]  w_ff, w_in;
   logic [SHIFT_W-1:0] s_ff, s_in;
   logic               zero_ff, zero_in, neg_ff, neg_in;
   logic [RATE_W-1:0]  m_ff, m_in;
   logic [FRAC_LOG-1:0] f_ff, f_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [LN_W-1:0] ln_a_ff, ln_a_in, ln_b_ff, ln_b_in, ln_d_ff, ln_d_in;

   logic [LEN_W-1:0]   len_c;
   logic               use_a;
   logic [RATE_W-1:0]  rate;
   logic signed [LN_W-1:0] ln_r;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  product;
   logic [MUL_A_W-1:0] twox, one_q32, dev;
   logic               top_zero;
   logic [WORD_W-1:0]  w_shift;
   logic [SHIFT_W-1:0] amt;
   logic signed [EXP_W-1:0] ex;
   logic signed [LG_W-1:0]  lg;
   logic [PROD_W-1:0]  rnd;
   logic signed [LN_W-1:0] res_mag, res;
   logic signed [LN_W:0]   term;
   logic signed [ACC_W:0]  sum;
   logic [LEN_W-1:0]   pos_plus;

   assign len_c = (length_ff == '0) ? LEN_W'(1) :
                  (length_ff > LEN_W'(SEQ_MAX)) ? LEN_W'(SEQ_MAX) : length_ff;
   assign use_a = pattern_ff[pos_ff];
   assign rate  = use_a ? a_ff : b_ff;
   assign ln_r  = use_a ? ln_a_ff : ln_b_ff;

   assign status.done    = step_ff >= total_ff;
   assign status.in_main = step_ff >= {1'b0, warm_ff};

   assign one_q32 = {1'b1, 32'd0};
   assign twox    = {x_ff, 1'b0};
   assign dev     = (twox <= one_q32) ? (one_q32 - twox) : (twox - one_q32);

   always_comb begin
      unique case (cmd.op)
         OP_MUL_P: begin
            mul_a = one_q32 - {1'b0, x_ff};
            mul_b = x_ff;
         end
         OP_MUL_X: begin
            mul_a = {1'b0, p_ff};
            mul_b = rate;
         end
         OP_SQUARE: begin
            mul_a = {1'b0, m_ff};
            mul_b = m_ff;
         end
         OP_LOG_MUL: begin
            mul_a = {{(MUL_A_W-MAG_W){1'b0}}, mag_ff};
            mul_b = LN2_Q32;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

   always_comb begin
      unique case (cmd.stage)
         3'd0: begin top_zero = (w_ff[33:2] == '0); w_shift = w_ff << 32; amt = 6'd32; end
         3'd1: begin top_zero = (w_ff[33:18] == '0); w_shift = w_ff << 16; amt = 6'd16; end
         3'd2: begin top_zero = (w_ff[33:26] == '0); w_shift = w_ff << 8; amt = 6'd8; end
         3'd3: begin top_zero = (w_ff[33:30] == '0); w_shift = w_ff << 4; amt = 6'd4; end
         3'd4: begin top_zero = (w_ff[33:32] == '0); w_shift = w_ff << 2; amt = 6'd2; end
         3'd5: begin top_zero = ~w_ff[33]; w_shift = w_ff << 1; amt = 6'd1; end
         default: begin top_zero = 1'b0; w_shift = w_ff; amt = '0; end
      endcase
   end

   assign ex  = ((cmd.src == SRC_D) ? 7'sd1 : 7'sd4) - $signed({1'b0, s_ff});
   assign lg  = $signed({ex, f_ff});
   assign rnd = prod_ff + (PROD_W'(1) << 35);
   assign res_mag = $signed(rnd[59:36]);
   assign res = neg_ff ? -res_mag : res_mag;

   assign term = (LN_W+1)'(ln_r) + (LN_W+1)'(ln_d_ff);
   assign sum  = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(term);
   assign pos_plus = {1'b0, pos_ff} + LEN_W'(1);

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      warm_in    = warm_ff;
      main_in    = main_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN: pattern_in = csr_data;
            CSR_LENGTH:  length_in  = csr_data[LEN_W-1:0];
            CSR_WARM:    warm_in    = csr_data[STEPS_W-1:0];
            CSR_MAIN:    main_in    = csr_data[STEPS_W-1:0];
         endcase
      end
   end

   always_comb begin
      a_in = a_ff;  b_in = b_ff;  x_in = x_ff;  p_in = p_ff;
      acc_in = acc_ff;  out_in = out_ff;
      step_in = step_ff;  total_in = total_ff;  pos_in = pos_ff;
      w_in = w_ff;  s_in = s_ff;  zero_in = zero_ff;  neg_in = neg_ff;
      m_in = m_ff;  f_in = f_ff;  mag_in = mag_ff;  prod_in = prod_ff;
      ln_a_in = ln_a_ff;  ln_b_in = ln_b_ff;  ln_d_in = ln_d_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            a_in = req_a_value;
            b_in = req_b_value;
            x_in = ORBIT_INIT;
            acc_in = '0;
            step_in = '0;
            pos_in = '0;
            total_in = {1'b0, warm_ff} + {1'b0, main_ff};
         end
         OP_LOG_LOAD: begin
            unique case (cmd.src)
               SRC_A:   w_in = {2'b00, a_ff};
               SRC_B:   w_in = {2'b00, b_ff};
               default: w_in = {1'b0, dev};
            endcase
            zero_in = (w_in == '0);
            s_in = '0;
         end
         OP_NORM: begin
            if (top_zero) begin
               w_in = w_shift;
               s_in = s_ff + amt;
            end
         end
         OP_MANT: begin
            m_in = w_ff[33:2];
            f_in = '0;
         end
         OP_SQUARE: begin
            if (product[63]) begin
               m_in = product[63:32];
               f_in = {f_ff[FRAC_LOG-2:0], 1'b1};
            end else begin
               m_in = product[62:31];
               f_in = {f_ff[FRAC_LOG-2:0], 1'b0};
            end
         end
         OP_LOG_EXP: begin
            neg_in = lg[LG_W-1];
            mag_in = lg[LG_W-1] ? MAG_W'(-lg) : MAG_W'(lg);
         end
         OP_LOG_MUL: prod_in = product;
         OP_LOG_FIN: begin
            unique case (cmd.src)
               SRC_A:   ln_a_in = (zero_ff || res < LOG_FLOOR) ? LOG_FLOOR : res;
               SRC_B:   ln_b_in = (zero_ff || res < LOG_FLOOR) ? LOG_FLOOR : res;
               default: ln_d_in = (zero_ff || res < LOG_FLOOR) ? LOG_FLOOR : res;
            endcase
         end
         OP_MUL_P: p_in = product[63:32];
         OP_MUL_X: x_in = (product[64:61] != '0) ? '1 : product[60:29];
         OP_STEP_END: begin
            if (status.in_main) begin
               if (sum > (ACC_W+1)'(ACC_MAX)) acc_in = ACC_MAX;
               else if (sum < (ACC_W+1)'(ACC_MIN)) acc_in = ACC_MIN;
               else acc_in = sum[ACC_W-1:0];
            end
            step_in = step_ff + COUNT_W'(1);
            pos_in = (pos_plus >= len_c) ? '0 : pos_plus[POS_W-1:0];
         end
         OP_PUBLISH: out_in = acc_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_RST;
         length_ff  <= LENGTH_RST;
         warm_ff    <= WARM_RST;
         main_ff    <= MAIN_RST;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
         warm_ff    <= warm_in;
         main_ff    <= main_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;  b_ff <= b_in;  x_ff <= x_in;  p_ff <= p_in;
      acc_ff <= acc_in;  out_ff <= out_in;
      step_ff <= step_in;  total_ff <= total_in;  pos_ff <= pos_in;
      w_ff <= w_in;  s_ff <= s_in;  zero_ff <= zero_in;  neg_ff <= neg_in;
      m_ff <= m_in;  f_ff <= f_in;  mag_ff <= mag_in;  prod_ff <= prod_in;
      ln_a_ff <= ln_a_in;  ln_b_ff <= ln_b_in;  ln_d_ff <= ln_d_in;
   end

   assign rsp_exponent_sum = out_ff;

endmodule

// ===== design/lep_controller.sv =====
// Controller: sequences logs, logistic steps and result handoff.
module lep_controller import lep_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LG_LOAD  = 4'd1;
   localparam logic [3:0] S_NORM     = 4'd2;
   localparam logic [3:0] S_MANT     = 4'd3;
   localparam logic [3:0] S_SQUARE   = 4'd4;
   localparam logic [3:0] S_LG_EXP   = 4'd5;
   localparam logic [3:0] S_LG_MUL   = 4'd6;
   localparam logic [3:0] S_LG_FIN   = 4'd7;
   localparam logic [3:0] S_CHECK    = 4'd8;
   localparam logic [3:0] S_MUL_P    = 4'd9;
   localparam logic [3:0] S_MUL_X    = 4'd10;
   localparam logic [3:0] S_STEP_END = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        src_ff, src_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.src      = src_ff;
      cmd.stage    = cnt_ff[2:0];
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               src_in   = SRC_A;
               state_in = S_LG_LOAD;
            end
         end
         S_LG_LOAD: begin
            cmd.op   = OP_LOG_LOAD;
            cnt_in   = '0;
            state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op = OP_NORM;
            if (cnt_ff == ITER_W'(NORM_STAGES - 1)) begin
               state_in = S_MANT;
            end else begin
               cnt_in = cnt_ff + ITER_W'(1);
            end
         end
         S_MANT: begin
            cmd.op   = OP_MANT;
            cnt_in   = '0;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.op = OP_SQUARE;
            if (cnt_ff == ITER_W'(SQ_ITERS - 1)) begin
               state_in = S_LG_EXP;
            end else begin
               cnt_in = cnt_ff + ITER_W'(1);
            end
         end
         S_LG_EXP: begin
            cmd.op   = OP_LOG_EXP;
            state_in = S_LG_MUL;
         end
         S_LG_MUL: begin
            cmd.op   = OP_LOG_MUL;
            state_in = S_LG_FIN;
         end
         S_LG_FIN: begin
            cmd.op = OP_LOG_FIN;
            unique case (src_ff)
               SRC_A: begin
                  src_in   = SRC_B;
                  state_in = S_LG_LOAD;
               end
               SRC_B:   state_in = S_CHECK;
               default: state_in = S_STEP_END;
            endcase
         end
         S_CHECK: begin
            state_in = status.done ? S_DONE : S_MUL_P;
         end
         S_MUL_P: begin
            cmd.op   = OP_MUL_P;
            state_in = S_MUL_X;
         end
         S_MUL_X: begin
            cmd.op = OP_MUL_X;
            if (status.in_main) begin
               src_in   = SRC_D;
               state_in = S_LG_LOAD;
            end else begin
               state_in = S_STEP_END;
            end
         end
         S_STEP_END: begin
            cmd.op   = OP_STEP_END;
            state_in = S_CHECK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         src_ff       <= SRC_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lyapunov_exponent_pixel.sv =====
// Logs share the 33x32 multiplier: load, 6 normalize, mantissa, 20 squarings, exp, mul, finish.
// Throughput: one pixel at a time; the next request is taken once the result is registered.
// A finished result waits in the output register while the next pixel runs.
// Reset (synchronous, active high) restores the settings 1, 2, 600, 2000 and empties the block.
module lyapunov_exponent_pixel import lep_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [RATE_W-1:0]       req_a_value,
   input  logic [RATE_W-1:0]       req_b_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [ACC_W-1:0] rsp_exponent_sum,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lep_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lep_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_a_value      (req_a_value),
      .req_b_value      (req_b_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_exponent_sum (rsp_exponent_sum)
   );

endmodule

// ===== design/lep_checker.sv =====
// Port-level checks of the pixel block and their bind.
`include "lyapunov_exponent_pixel_macros.svh"

module lep_port_checks import lep_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [ACC_W-1:0] rsp_exponent_sum
);

   `LEP_ASSERT_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_exponent_sum))
   `LEP_ASSERT_NEXT(busy_after_req, req_valid && req_ready, !req_ready)
   `LEP_ASSERT_NEXT(idle_stays, req_ready && !req_valid, req_ready)
   `LEP_ASSERT_SAME(rsp_with_idle, $rose(rsp_valid), req_ready)

endmodule

bind lyapunov_exponent_pixel lep_port_checks u_lep_port_checks (.*);
